@@ rtl/mts_pkg.sv @@
// Shared types, codes and helpers for the max-tracking stack.
// Used by max_tracking_stack; no dependencies.
package mts_pkg;

    localparam int VALUE_W = 32;
    localparam int WORD_W  = 34;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

    // packed so that popped_value lands in the lowest bits
    typedef struct packed {
        logic [1:0]         status;
        logic               is_empty;
        logic [VALUE_W-1:0] max_value;
        logic [VALUE_W-1:0] top_value;
        logic [VALUE_W-1:0] popped_value;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    function automatic logic [WORD_W-1:0] sext_value(input logic [VALUE_W-1:0] v);
        sext_value = {{(WORD_W-VALUE_W){v[VALUE_W-1]}}, v};
    endfunction

    // stored word above max is encoded; the element it stands for is the max
    function automatic logic [VALUE_W-1:0] decode_top(input logic [WORD_W-1:0] w,
                                                     input logic [VALUE_W-1:0] m);
        logic signed [WORD_W-1:0] ms;
        ms = $signed(sext_value(m));
        decode_top = ($signed(w) > ms) ? m : w[VALUE_W-1:0];
    endfunction

endpackage

@@ rtl/mts_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mts_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/max_tracking_stack.sv @@
// Stack of signed 32-bit values that reports its maximum, top element and fill state.
// Depends on mts_pkg and mts_ram.
//
// Each input beat is a push (tuser 0) or a pop (tuser 1) and yields one output beat.
// Only the current maximum and a copy of the top stored word sit in registers; the
// entries live in a single RAM, and a pushed value above the maximum is stored as
// 2*value-max so the old maximum can be recovered on pop. A push, and a pop on an
// empty stack or one that empties it, complete in the IDLE state. A pop that leaves
// entries also passes through the POPRD state to take the new top from the RAM's
// registered read port. A push onto a full stack is dropped, reported with status 2.
// The output register lets the next beat be taken in the cycle its result is read.
module max_tracking_stack #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [31:0]                  i_s_tdata,   // value[31:0]
    input  logic                         i_s_tuser,   // kind[0]
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // popped_value[31:0], top_value[63:32], max_value[95:64], is_empty[96],
    // status[98:97], zero pad
    output logic [mts_pkg::M_DATA_W-1:0] o_m_tdata
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = mts_pkg::VALUE_W;
    localparam int WW = mts_pkg::WORD_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_POPRD = 1'b1;

    logic                 r_state, n_state;
    logic [CW-1:0]        r_fill, n_fill;
    logic [VW-1:0]        r_max, n_max;
    logic [WW-1:0]        r_top, n_top;
    mts_pkg::t_result     r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 s_accept;
    logic                 ram_we;
    logic [WW-1:0]        ram_wdata;
    logic [WW-1:0]        ram_rdata;
    logic [CW-1:0]        rd_ptr;

    logic [WW-1:0]        val_w;
    logic [WW-1:0]        max_w;
    logic                 push_above;
    logic                 top_encoded;
    logic [WW-1:0]        restore_max;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign rd_ptr     = r_fill - CW'(2);

    assign val_w       = mts_pkg::sext_value(i_s_tdata);
    assign max_w       = mts_pkg::sext_value(r_max);
    assign push_above  = $signed(val_w) > $signed(max_w);
    assign top_encoded = $signed(r_top) > $signed(max_w);
    assign restore_max = {r_max[VW-1], r_max, 1'b0} - r_top;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_max       = r_max;
        n_top       = r_top;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        ram_we      = 1'b0;
        ram_wdata   = val_w;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_out_valid        = 1'b1;
                    n_out.popped_value = '0;
                    n_out.status       = mts_pkg::STATUS_OK;
                    if (i_s_tuser == mts_pkg::KIND_PUSH) begin
                        if (r_fill == CW'(STACK_DEPTH)) begin
                            n_out.status    = mts_pkg::STATUS_PUSH_FULL;
                            n_out.top_value = mts_pkg::decode_top(r_top, r_max);
                            n_out.max_value = r_max;
                            n_out.is_empty  = 1'b0;
                        end else begin
                            ram_we = 1'b1;
                            if (r_fill == '0) begin
                                ram_wdata = val_w;
                                n_max     = i_s_tdata;
                            end else if (push_above) begin
                                ram_wdata = {i_s_tdata[VW-1], i_s_tdata, 1'b0} - max_w;
                                n_max     = i_s_tdata;
                            end
                            n_top           = ram_wdata;
                            n_fill          = r_fill + CW'(1);
                            n_out.top_value = mts_pkg::decode_top(ram_wdata, n_max);
                            n_out.max_value = n_max;
                            n_out.is_empty  = 1'b0;
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_out.status    = mts_pkg::STATUS_POP_EMPTY;
                            n_out.top_value = '0;
                            n_out.max_value = '0;
                            n_out.is_empty  = 1'b1;
                        end else begin
                            n_fill = r_fill - CW'(1);
                            if (top_encoded) begin
                                n_out.popped_value = r_max;
                                n_max              = restore_max[VW-1:0];
                            end else begin
                                n_out.popped_value = r_top[VW-1:0];
                            end
                            if (r_fill == CW'(1)) begin
                                n_out.top_value = '0;
                                n_out.max_value = '0;
                                n_out.is_empty  = 1'b1;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = ST_POPRD;
                            end
                        end
                    end
                end
            end
            ST_POPRD: begin
                n_top           = ram_rdata;
                n_out.top_value = mts_pkg::decode_top(ram_rdata, r_max);
                n_out.max_value = r_max;
                n_out.is_empty  = 1'b0;
                n_out_valid     = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
        r_top <= n_top;
        r_out <= n_out;
    end

    mts_ram #(
        .WIDTH(WW),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(ram_wdata),
        .i_raddr(rd_ptr[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(mts_pkg::M_DATA_W - mts_pkg::RESULT_W)'(0), r_out};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(STACK_DEPTH))
        else $error("fill count above depth");

    a_poprd_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POPRD) |-> !r_out_valid)
        else $error("output slot busy while fetching new top");

    a_poprd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POPRD) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("pop result not delivered after top fetch");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_empty == (r_fill == '0)))
        else $error("empty flag disagrees with fill count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser == mts_pkg::KIND_PUSH && r_fill != CW'(STACK_DEPTH))
        |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("push did not grow the stack");

endmodule

@@ dv/tb_max_tracking_stack.sv @@
// Self-checking testbench for max_tracking_stack: directed table, then random push/pop beats.
// Depends on mts_pkg and the RTL; expected results: typed table rows, else an in-bench predictor.
module tb_max_tracking_stack;

    localparam int DEPTH     = 256;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic             kind;
        logic [31:0]      value;
        bit               has_exp;
        mts_pkg::t_result res;
    } t_dir_row;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [31:0]                  i_s_tdata  = '0;  // value[31:0]
    logic                         i_s_tuser  = 1'b0;  // kind[0]
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    // popped_value[31:0], top_value[63:32], max_value[95:64], is_empty[96],
    // status[98:97], zero pad
    logic [mts_pkg::M_DATA_W-1:0] o_m_tdata;

    logic signed [mts_pkg::WORD_W-1:0] stack_words [DEPTH];
    int                                stack_fill = 0;
    logic [mts_pkg::VALUE_W-1:0]       stack_max  = '0;

    mts_pkg::t_result pending_results [$];
    t_dir_row         dir_rows [$];
    int               src_idle_pct = 0;
    int               dst_idle_pct = 0;
    int               mismatches   = 0;
    int               cycles       = 0;

    max_tracking_stack #(.STACK_DEPTH(DEPTH)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic mts_pkg::t_result result_of(logic [31:0] popped, logic [31:0] top,
                                                   logic [31:0] mx, logic empty,
                                                   logic [1:0] st);
        mts_pkg::t_result r;
        r.popped_value = popped;
        r.top_value    = top;
        r.max_value    = mx;
        r.is_empty     = empty;
        r.status       = st;
        return r;
    endfunction

    // push stores 2*v-max when v beats the max; pop of a word above max restores it
    function automatic mts_pkg::t_result stack_apply(logic kind, logic [31:0] v);
        logic signed [mts_pkg::WORD_W-1:0] val;
        logic signed [mts_pkg::WORD_W-1:0] mx;
        logic signed [mts_pkg::WORD_W-1:0] word;
        logic signed [mts_pkg::WORD_W-1:0] restored;
        mts_pkg::t_result                  r;
        r   = '0;
        val = $signed(v);
        mx  = $signed(stack_max);
        if (kind == mts_pkg::KIND_PUSH) begin
            if (stack_fill >= DEPTH) begin
                r.status = mts_pkg::STATUS_PUSH_FULL;
            end else if (stack_fill == 0) begin
                stack_words[0] = val;
                stack_max      = v;
                stack_fill     = 1;
            end else begin
                if (val > mx) begin
                    stack_words[stack_fill] = 2 * val - mx;
                    stack_max               = v;
                end else begin
                    stack_words[stack_fill] = val;
                end
                stack_fill++;
            end
        end else begin
            if (stack_fill == 0) begin
                r.status = mts_pkg::STATUS_POP_EMPTY;
            end else begin
                word = stack_words[stack_fill-1];
                stack_fill--;
                if (word > mx) begin
                    r.popped_value = stack_max;
                    restored       = 2 * mx - word;
                    stack_max      = restored[mts_pkg::VALUE_W-1:0];
                end else begin
                    r.popped_value = word[mts_pkg::VALUE_W-1:0];
                end
            end
        end
        if (stack_fill == 0) begin
            r.is_empty = 1'b1;
        end else begin
            word        = stack_words[stack_fill-1];
            mx          = $signed(stack_max);
            r.top_value = (word > mx) ? stack_max : word[mts_pkg::VALUE_W-1:0];
            r.max_value = stack_max;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(16) - 8;
            3:       return stack_max + $urandom_range(4) - 2;
            default: return $urandom;
        endcase
    endfunction

    // sends one beat; a typed expectation overrides the predicted one
    task automatic send_beat(logic kind, logic [31:0] v, bit has_exp,
                             mts_pkg::t_result fixed);
        mts_pkg::t_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= v;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = stack_apply(kind, v);
        pending_results.push_back(has_exp ? fixed : predicted);
    endtask

    task automatic send_random(int count, int push_pct);
        logic kind;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(99) < push_pct) ? mts_pkg::KIND_PUSH : mts_pkg::KIND_POP;
            send_beat(kind, pick_value(), 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        mts_pkg::t_result got;
        mts_pkg::t_result want;
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[mts_pkg::RESULT_W-1:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got.popped_value !== want.popped_value ||
                    got.top_value !== want.top_value ||
                    got.max_value !== want.max_value || got.is_empty !== want.is_empty ||
                    got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp pop=%h top=%h max=%h empty=%b st=%0d",
                                  " | got pop=%h top=%h max=%h empty=%b st=%0d"},
                                 want.popped_value, want.top_value, want.max_value,
                                 want.is_empty, want.status, got.popped_value,
                                 got.top_value, got.max_value, got.is_empty, got.status);
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    initial begin
        dir_rows.push_back('{mts_pkg::KIND_POP, 32'h1234_5678, 1'b1,
            result_of(32'd0, 32'd0, 32'd0, 1'b1, mts_pkg::STATUS_POP_EMPTY)});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'h7FFF_FFFF, 1'b1,
            result_of(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, mts_pkg::STATUS_OK)});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'h8000_0000, 1'b1,
            result_of(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, mts_pkg::STATUS_OK)});
        dir_rows.push_back('{mts_pkg::KIND_POP, 32'hFFFF_FFFF, 1'b1,
            result_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0,
                      mts_pkg::STATUS_OK)});
        dir_rows.push_back('{mts_pkg::KIND_POP, 32'h0000_0000, 1'b1,
            result_of(32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1, mts_pkg::STATUS_OK)});
        // empty again with a stale max inside
        dir_rows.push_back('{mts_pkg::KIND_POP, 32'hFFFF_FFFF, 1'b1,
            result_of(32'd0, 32'd0, 32'd0, 1'b1, mts_pkg::STATUS_POP_EMPTY)});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'h8000_0000, 1'b1,
            result_of(32'd0, 32'h8000_0000, 32'h8000_0000, 1'b0, mts_pkg::STATUS_OK)});
        // widest encoded word: max positive over max negative
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'h7FFF_FFFF, 1'b0, '0});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'h0000_0000, 1'b0, '0});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'h7FFF_FFFF, 1'b0, '0});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'hFFFF_FFFF, 1'b0, '0});
        for (int n = 0; n < 5; n++)
            dir_rows.push_back('{mts_pkg::KIND_POP, 32'h5A5A_A5A5, 1'b0, '0});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'd10, 1'b0, '0});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'd30, 1'b0, '0});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'd20, 1'b0, '0});
        dir_rows.push_back('{mts_pkg::KIND_PUSH, 32'd40, 1'b0, '0});
        for (int n = 0; n < 5; n++)
            dir_rows.push_back('{mts_pkg::KIND_POP, 32'hA5A5_5A5A, 1'b0, '0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 9;
        dst_idle_pct = 55;
        foreach (dir_rows[n])
            send_beat(dir_rows[n].kind, dir_rows[n].value, dir_rows[n].has_exp,
                      dir_rows[n].res);
        wait_drained();
        send_random(55, 55);

        src_idle_pct = 55;
        dst_idle_pct = 9;
        send_random(55, 45);
        wait_drained();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        while (stack_fill < DEPTH)
            send_beat(mts_pkg::KIND_PUSH, pick_value(), 1'b0, '0);
        repeat (3) send_beat(mts_pkg::KIND_PUSH, pick_value(), 1'b0, '0);
        send_random(20, 60);
        while (stack_fill > 0)
            send_beat(mts_pkg::KIND_POP, $urandom, 1'b0, '0);
        repeat (2) send_beat(mts_pkg::KIND_POP, $urandom, 1'b0, '0);

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
